// File: design/mlcrf_pkg.sv
// Shared types, constants and helper functions for the load-cell reply filter.
`default_nettype none

package mlcrf_pkg;

  // Width of the scaled gram values (signed fixed point)
  localparam int VALUE_WIDTH = 40;

  // Frame layout
  localparam logic [3:0]  FRAME_LEN  = 4'd9;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  BYTE_COUNT = 8'h04;

  // Modbus CRC-16
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes
  localparam logic [1:0] REG_STATION_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SMOOTHING_GAIN  = 2'd1;
  localparam logic [1:0] REG_GRAMS_PER_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  RST_STATION_ADDRESS = 8'd1;
  localparam logic [15:0] RST_SMOOTHING_GAIN  = 16'd9830;
  localparam logic [31:0] RST_GRAMS_PER_COUNT = 32'd681783;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_buffer;
  } in_beat_t;

  typedef struct packed {
    logic                          frame_status;
    logic signed [31:0]            raw_reading;
    logic signed [VALUE_WIDTH-1:0] median_grams;
    logic signed [VALUE_WIDTH-1:0] filtered_grams;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CRC,
    ST_CMP,
    ST_MUL_SCALE,
    ST_SCALE,
    ST_TAPS,
    ST_MED,
    ST_SEED,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_STEP
  } state_t;

  // One byte of the reflected CRC-16: eight shift/xor steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Median of three signed values
  function automatic logic signed [VALUE_WIDTH-1:0] median3(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b,
      input logic signed [VALUE_WIDTH-1:0] c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      return b;
    end
    if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      return a;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/modbus_load_cell_reply_filter_top.sv
// Top level: Modbus load-cell reply parser with CRC check, scaling, median and low-pass.
//
// Usage:
//   in_*  : one received byte per beat (rx_byte, last_in_buffer). A 9-byte
//           sliding window is kept; a window that starts with station_address,
//           0x03, 0x04 is checked as a frame and produces one out beat.
//   out_* : frame_status (0 good, 1 CRC error), raw_reading, median_grams,
//           filtered_grams (signed Q.FRACTION_BITS grams).
//   cfg_* : register write port, index 0 station_address, 1 smoothing_gain,
//           2 grams_per_count; user writes them only while idle, unchecked by the block.
// Timing:
//   A byte that does not complete the window is taken in ST_IDLE and in_ready
//   stays high. A full window with a wrong header passes through ST_CHECK only.
//   A frame runs the CRC one byte per cycle over bytes 0 to 6, then compares it
//   in ST_CMP; a CRC error loads the out beat from ST_CMP, while a good frame
//   goes through the shared 32x32 multiplier three times and loads the out beat
//   from ST_STEP.
// Reset (rst, synchronous): window empty, median taps and filter state zero,
//   registers at their reset values, no out beat pending.
// Stall: the result sits in an output register; bytes keep being accepted
//   while it waits. A later result holds the sequencer until out_ready takes
//   the pending beat.
`default_nettype none

module modbus_load_cell_reply_filter_top
  import mlcrf_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int VW     = VALUE_WIDTH;
  localparam int ACC_W  = VW + 16;
  localparam int SH     = 32 - FRACTION_BITS;
  localparam logic [63:0] RND_BIT = 64'd1 << (SH - 1);
  localparam logic [63:0] LIM     = 64'd1 << (VW - 1);
  localparam int LP_THR_INT = ((1 << FRACTION_BITS) + 999) / 1000;
  localparam logic signed [VW-1:0] LP_THR = VW'(LP_THR_INT);
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(32'h8000);

  // Configuration registers
  logic [7:0]  station_address;
  logic [15:0] smoothing_gain;
  logic [31:0] grams_per_count;

  // Sequencer
  state_t state, state_next;
  logic   out_hold;
  logic   out_load;

  // Byte window
  logic [7:0] win [9];
  logic [3:0] fill;
  logic       last_q;
  logic       hdr_ok;

  // CRC engine
  logic [15:0] crc;
  logic [2:0]  crc_idx;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod;

  // Scaling
  logic [31:0]          raw_u;
  logic [31:0]          raw_mag;
  logic                 raw_neg;
  logic [63:0]          rnd_sum;
  logic [63:0]          scaled_mag;
  logic [63:0]          sat_mag;
  logic signed [VW-1:0] grams;
  logic signed [VW-1:0] grams_val;

  // Median
  logic signed [VW-1:0] taps [3];
  logic [1:0]           slot;
  logic [1:0]           slot_eff;
  logic                 taps_zero;
  logic signed [VW-1:0] med;

  // Low-pass
  logic signed [VW-1:0] smoothed;
  logic signed [VW-1:0] s_eff;
  logic                 lp_small;
  logic [VW:0]          diff;
  logic [VW:0]          diff_neg;
  logic                 ge;
  logic [63:0]          d64;
  logic [ACC_W-1:0]     acc;
  logic [95:0]          hi_shift;
  logic [VW-1:0]        q;
  logic signed [VW-1:0] s_new;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= RST_STATION_ADDRESS;
      smoothing_gain  <= RST_SMOOTHING_GAIN;
      grams_per_count <= RST_GRAMS_PER_COUNT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STATION_ADDRESS: station_address <= cfg_data[7:0];
        REG_SMOOTHING_GAIN:  smoothing_gain  <= cfg_data[15:0];
        REG_GRAMS_PER_COUNT: grams_per_count <= cfg_data;
        default: ;  // index beyond the list is ignored
      endcase
    end
  end

  // ---------------------------------------------------------- combinational
  assign hdr_ok = (win[0] == station_address) && (win[1] == FUNC_READ) &&
                  (win[2] == BYTE_COUNT);

  assign raw_u   = {win[3], win[4], win[5], win[6]};
  assign raw_neg = raw_u[31];
  assign raw_mag = raw_neg ? (32'd0 - raw_u) : raw_u;

  // Round to nearest (ties away) on the magnitude, then saturate
  assign rnd_sum    = prod + RND_BIT;
  assign scaled_mag = rnd_sum >> SH;
  always_comb begin
    if (raw_neg) begin
      sat_mag = (scaled_mag > LIM) ? LIM : scaled_mag;
      grams   = VW'(VW'(0) - sat_mag[VW-1:0]);
    end else begin
      sat_mag = (scaled_mag > LIM - 64'd1) ? (LIM - 64'd1) : scaled_mag;
      grams   = sat_mag[VW-1:0];
    end
  end

  assign slot_eff  = (slot == 2'd3) ? 2'd0 : slot;
  assign taps_zero = (taps[0] == '0) && (taps[1] == '0) && (taps[2] == '0);

  assign lp_small = (smoothed < LP_THR) && (smoothed > -LP_THR);

  assign diff     = {med[VW-1], med} - {s_eff[VW-1], s_eff};
  assign diff_neg = (VW+1)'(0) - diff;

  assign hi_shift = {prod, 32'd0};
  assign q        = acc[ACC_W-1:16];
  assign s_new    = ge ? (s_eff + q) : (s_eff - q);

  // Shared 32x32 multiplier
  always_comb begin
    unique case (state)
      ST_MUL_SCALE: begin
        mul_a = raw_mag;
        mul_b = grams_per_count;
      end
      ST_MUL_LO: begin
        mul_a = d64[31:0];
        mul_b = {16'd0, smoothing_gain};
      end
      ST_MUL_HI: begin
        mul_a = d64[63:32];
        mul_b = {16'd0, smoothing_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // ------------------------------------------------------------- sequencer
  assign out_hold = out_valid && !out_ready;
  assign in_ready = (state == ST_IDLE);
  // a new out beat is loaded on a CRC error or at the end of a good frame
  assign out_load = !out_hold &&
                    (((state == ST_CMP) && (crc != {win[8], win[7]})) ||
                     (state == ST_STEP));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && fill == FRAME_LEN - 4'd1) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK:     state_next = hdr_ok ? ST_CRC : ST_IDLE;
      ST_CRC:       state_next = (crc_idx == 3'd6) ? ST_CMP : ST_CRC;
      ST_CMP: begin
        if (crc == {win[8], win[7]}) begin
          state_next = ST_MUL_SCALE;
        end else if (!out_hold) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL_SCALE: state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_TAPS;
      ST_TAPS:      state_next = ST_MED;
      ST_MED:       state_next = ST_SEED;
      ST_SEED:      state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_MUL_LO;
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_ACC;
      ST_ACC:       state_next = ST_STEP;
      ST_STEP:      state_next = out_hold ? ST_STEP : ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      taps[0]   <= '0;
      taps[1]   <= '0;
      taps[2]   <= '0;
      slot      <= '0;
      smoothed  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_hold) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            win[fill] <= in_data.rx_byte;
            last_q    <= in_data.last_in_buffer;
            if (fill != FRAME_LEN - 4'd1) begin
              fill <= in_data.last_in_buffer ? 4'd0 : fill + 4'd1;
            end
          end
        end
        ST_CHECK: begin
          crc     <= CRC_INIT;
          crc_idx <= '0;
          if (hdr_ok) begin
            fill <= '0;
          end else begin
            // drop the oldest byte
            for (int i = 0; i < 8; i++) begin
              win[i] <= win[i+1];
            end
            fill <= last_q ? 4'd0 : FRAME_LEN - 4'd1;
          end
        end
        ST_CRC: begin
          crc     <= crc_byte(crc, win[{1'b0, crc_idx}]);
          crc_idx <= crc_idx + 3'd1;
        end
        ST_CMP: begin
          if (crc != {win[8], win[7]} && !out_hold) begin
            out_data.frame_status   <= 1'b1;
            out_data.raw_reading    <= '0;
            out_data.median_grams   <= '0;
            out_data.filtered_grams <= smoothed;
          end
        end
        ST_MUL_SCALE: prod <= mul_p;
        ST_SCALE:     grams_val <= grams;
        ST_TAPS: begin
          // seed all taps when they are all zero, then write the current slot
          for (int i = 0; i < 3; i++) begin
            if (slot_eff == 2'(i)) begin
              taps[i] <= grams_val;
            end else if (taps_zero) begin
              taps[i] <= grams_val;
            end
          end
          slot <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
        end
        ST_MED:  med   <= median3(taps[0], taps[1], taps[2]);
        ST_SEED: s_eff <= lp_small ? med : smoothed;
        ST_DIFF: begin
          ge  <= ~diff[VW];
          d64 <= 64'(diff[VW] ? diff_neg[VW-1:0] : diff[VW-1:0]);
        end
        ST_MUL_LO: prod <= mul_p;
        ST_MUL_HI: begin
          prod <= mul_p;
          acc  <= prod[ACC_W-1:0] + HALF_LSB;
        end
        ST_ACC: acc <= acc + hi_shift[ACC_W-1:0];
        ST_STEP: begin
          if (!out_hold) begin
            smoothed                <= s_new;
            out_data.frame_status   <= 1'b0;
            out_data.raw_reading    <= raw_u;
            out_data.median_grams   <= med;
            out_data.filtered_grams <= s_new;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
